>>> rtl/core/utt_pkg.sv
// ----------------------------------------------------------------------------
// utt_pkg: shared types and constants of the UTF-16 to UTF-8 transcoder
// Code unit classes, register indexes, byte encoding helpers and the
// descriptor that the front end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package utt_pkg;

    localparam int UNIT_W     = 16;  // one UTF-16 code unit
    localparam int LEN_W      = 20;  // reported length
    localparam int SUM_W      = LEN_W + 1;
    localparam int CAP_CFG_W  = 16;  // capacity register
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_RES    = 6;   // results one unit can cause
    localparam int CNT_W      = 3;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int CP_W       = 21;  // supplementary code point

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_ONLY = 1'd1;

    localparam logic [UNIT_W-1:0] ONE_BYTE_MAX  = 16'h007f;
    localparam logic [UNIT_W-1:0] TWO_BYTE_MAX  = 16'h07ff;
    localparam logic [UNIT_W-1:0] HIGH_SURR_LO  = 16'hd800;
    localparam logic [UNIT_W-1:0] HIGH_SURR_HI  = 16'hdbff;
    localparam logic [5:0]        HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0]        LOW_SURR_TAG  = 6'b110111;
    localparam logic [CP_W-1:0]   BMP_SPAN      = 21'h10000;

    localparam logic [7:0] LEAD2 = 8'hc0;
    localparam logic [7:0] LEAD3 = 8'he0;
    localparam logic [7:0] LEAD4 = 8'hf0;
    localparam logic [7:0] CONT  = 8'h80;

    typedef enum logic [1:0] {
        KIND_ONE,
        KIND_TWO,
        KIND_THREE,
        KIND_HOLD
    } unit_kind_t;

    // One queue entry: every result that one accepted unit causes
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] seq;     // bytes in output order, slot 0 first
        logic [CNT_W-1:0]        cnt;     // number of results, 1..MAX_RES
        logic                    has_end; // last slot closes the string
        logic                    end_wr;  // closing NUL is a real write
        logic [LEN_W-1:0]        len;
        logic                    trunc;
    } entry_t;

    // Three-byte form of a BMP unit
    function automatic logic [2:0][7:0] enc3(input logic [UNIT_W-1:0] u);
        logic [2:0][7:0] b;
        b[0] = LEAD3 | {4'b0, u[15:12]};
        b[1] = CONT  | {2'b0, u[11:6]};
        b[2] = CONT  | {2'b0, u[5:0]};
        return b;
    endfunction

    // Saturate a grown length
    function automatic logic [LEN_W-1:0] sat_len(input logic [SUM_W-1:0] s);
        return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
    endfunction

endpackage

>>> rtl/core/utt_front.sv
// ----------------------------------------------------------------------------
// utt_front: unit classifier and string state
// Holds the configuration and the per-string state, classifies each accepted
// code unit and builds, combinationally, the list of bytes it causes.
// ----------------------------------------------------------------------------
module utt_front #(
    parameter int MAX_CAPACITY = 65535
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [utt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [utt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            accept,
    input  logic [utt_pkg::UNIT_W-1:0]      code_unit,
    output logic                            enq_valid,
    output utt_pkg::entry_t                 enq_entry
);
    import utt_pkg::*;

    localparam int CAP_W = $clog2(MAX_CAPACITY + 1);

    logic [CAP_CFG_W-1:0] capacity_reg, capacity_next;
    logic                 count_only_reg, count_only_next;
    logic [9:0]           held_reg, held_next;
    logic                 held_valid_reg, held_valid_next;
    logic [LEN_W-1:0]     bsf_reg, bsf_next;
    logic                 stopped_reg, stopped_next;

    logic [CAP_W-1:0]     cap_eff;
    logic [SUM_W-1:0]     cap_ext;
    logic                 go0, flush, pair, go_b, is_end, do_b, hold_b, seq_b;
    logic [UNIT_W-1:0]    hi_unit;
    logic [CP_W-1:0]      cp;
    logic [3:0][7:0]      bytes_a;
    logic [2:0][7:0]      bytes_b;
    logic [CNT_W-1:0]     n_a, n_b, off_b, cnt;
    logic [SUM_W-1:0]     sum_a, sum_b;
    logic                 fit_a, fit_b, emit_a, emit_b, stop_a, stop_b;
    logic [LEN_W-1:0]     bsf_a, bsf_b;
    unit_kind_t           kind;
    logic [CNT_W-1:0]     kk, rel;

    // Clamp capacity to the largest supported buffer
    always_comb
    begin
        if ({{(SUM_W-CAP_CFG_W){1'b0}}, capacity_reg} > SUM_W'(MAX_CAPACITY))
            cap_eff = CAP_W'(MAX_CAPACITY);
        else
            cap_eff = CAP_W'(capacity_reg);
        cap_ext = SUM_W'(cap_eff);
    end

    // Classify the incoming unit
    always_comb
    begin
        if (code_unit inside {[16'h0000:ONE_BYTE_MAX]})
            kind = KIND_ONE;
        else if (code_unit inside {[16'h0080:TWO_BYTE_MAX]})
            kind = KIND_TWO;
        else if (code_unit inside {[HIGH_SURR_LO:HIGH_SURR_HI]})
            kind = KIND_HOLD;
        else
            kind = KIND_THREE;
    end

    // Encode the unit's own sequence
    always_comb
    begin
        bytes_b = enc3(code_unit);
        n_b     = 3'd3;
        case (kind)
            KIND_ONE:
            begin
                bytes_b[0] = code_unit[7:0];
                n_b        = 3'd1;
            end
            KIND_TWO:
            begin
                bytes_b[0] = LEAD2 | {3'b0, code_unit[10:6]};
                bytes_b[1] = CONT  | {2'b0, code_unit[5:0]};
                n_b        = 3'd2;
            end
            default:
            begin
                bytes_b = enc3(code_unit);
                n_b     = 3'd3;
            end
        endcase
    end

    // Flush the held high surrogate, then handle the unit itself
    always_comb
    begin
        go0     = count_only_reg || !stopped_reg;
        flush   = go0 && held_valid_reg;
        pair    = flush && (code_unit[15:10] == LOW_SURR_TAG);
        hi_unit = {HIGH_SURR_TAG, held_reg};
        cp      = BMP_SPAN + CP_W'({held_reg, code_unit[9:0]});

        if (pair)
        begin
            bytes_a[0] = LEAD4 | {5'b0, cp[20:18]};
            bytes_a[1] = CONT  | {2'b0, cp[17:12]};
            bytes_a[2] = CONT  | {2'b0, cp[11:6]};
            bytes_a[3] = CONT  | {2'b0, cp[5:0]};
            n_a        = 3'd4;
        end
        else
        begin
            bytes_a[2:0] = enc3(hi_unit);
            bytes_a[3]   = '0;
            n_a          = 3'd3;
        end

        // bsf + n + 1 <= cap is the same as bsf + n < cap
        sum_a  = {1'b0, bsf_reg} + SUM_W'(n_a);
        fit_a  = sum_a < cap_ext;
        emit_a = flush && !count_only_reg && fit_a;
        stop_a = stopped_reg || (flush && !count_only_reg && !fit_a);
        if (!flush)
            bsf_a = bsf_reg;
        else if (count_only_reg)
            bsf_a = sat_len(sum_a);
        else if (fit_a)
            bsf_a = sum_a[LEN_W-1:0];
        else
            bsf_a = bsf_reg;

        go_b   = go0 && !(flush && !count_only_reg && !fit_a);
        is_end = !pair && (code_unit == '0);
        do_b   = !pair && !is_end && go_b;
        hold_b = do_b && (kind == KIND_HOLD);
        seq_b  = do_b && (kind != KIND_HOLD);

        sum_b  = {1'b0, bsf_a} + SUM_W'(n_b);
        fit_b  = sum_b < cap_ext;
        emit_b = seq_b && !count_only_reg && fit_b;
        stop_b = stop_a || (seq_b && !count_only_reg && !fit_b);
        if (!seq_b)
            bsf_b = bsf_a;
        else if (count_only_reg)
            bsf_b = sat_len(sum_b);
        else if (fit_b)
            bsf_b = sum_b[LEN_W-1:0];
        else
            bsf_b = bsf_a;
    end

    // Pack the results into slots: flushed sequence, own sequence, NUL
    always_comb
    begin
        off_b = emit_a ? n_a : '0;
        cnt   = (emit_a ? n_a : '0) + (emit_b ? n_b : '0) + CNT_W'(is_end);
        kk    = '0;
        rel   = '0;
        enq_entry.seq = '0;
        for (int k = 0; k < MAX_RES; k++)
        begin
            kk  = CNT_W'(k);
            rel = kk - off_b;
            if (emit_a && kk < n_a)
                enq_entry.seq[k] = bytes_a[kk[1:0]];
            else if (emit_b && kk >= off_b && rel < n_b)
                enq_entry.seq[k] = bytes_b[rel[1:0]];
        end
        enq_entry.cnt     = cnt;
        enq_entry.has_end = is_end;
        enq_entry.end_wr  = !count_only_reg;
        enq_entry.len     = bsf_a;
        enq_entry.trunc   = !count_only_reg && stop_a;
        enq_valid         = accept && (cnt != '0);
    end

    // Next string state and configuration
    always_comb
    begin
        capacity_next   = capacity_reg;
        count_only_next = count_only_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        bsf_next        = bsf_reg;
        stopped_next    = stopped_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CAPACITY:   capacity_next   = cfg_wdata;
                REG_COUNT_ONLY: count_only_next = cfg_wdata[0];
                default:        ;
            endcase
        end

        if (accept)
        begin
            if (is_end)
            begin
                held_next       = '0;
                held_valid_next = 1'b0;
                bsf_next        = '0;
                stopped_next    = 1'b0;
            end
            else
            begin
                bsf_next     = bsf_b;
                stopped_next = stop_b;
                if (hold_b)
                begin
                    held_next       = code_unit[9:0];
                    held_valid_next = 1'b1;
                end
                else if (flush)
                begin
                    held_next       = '0;
                    held_valid_next = 1'b0;
                end
            end
        end
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= CAP_CFG_W'(256);
            count_only_reg <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            bsf_reg        <= '0;
            stopped_reg    <= 1'b0;
        end
        else
        begin
            capacity_reg   <= capacity_next;
            count_only_reg <= count_only_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            bsf_reg        <= bsf_next;
            stopped_reg    <= stopped_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A terminator leaves the string state clean
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && code_unit == '0) |=>
            (bsf_reg == '0 && !held_valid_reg && !stopped_reg))
        else $error("string state not cleared after terminator");

    // Write mode never advances the length to the capacity or beyond
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !count_only_reg && enq_valid && !enq_entry.has_end) |->
            (bsf_b < LEN_W'(cap_eff)))
        else $error("write mode length reached capacity");
`endif

endmodule

>>> rtl/core/utt_queue.sv
// ----------------------------------------------------------------------------
// utt_queue: descriptor queue between front and back end
// A short register queue that lets the front take units while the back end
// still drains earlier bytes.
// ----------------------------------------------------------------------------
module utt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  utt_pkg::entry_t wr_data,
    input  logic            rd_en,
    output logic            rd_valid,
    output utt_pkg::entry_t rd_data,
    output logic            full
);
    import utt_pkg::*;

    entry_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]     count_reg, count_next;
    logic                 do_wr, do_rd;

    // Advance pointers and occupancy
    always_comb
    begin
        do_wr       = wr_en && !full;
        do_rd       = rd_en && rd_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + (Q_PTR_W+1)'(do_wr) - (Q_PTR_W+1)'(do_rd);
    end

    assign full     = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

`ifndef NO_ASSERTIONS
    // Occupancy stays within depth
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (Q_PTR_W+1)'(Q_DEPTH))
        else $error("queue occupancy out of range");

    // No write is offered while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("write into full queue");
`endif

endmodule

>>> rtl/core/utt_back.sv
// ----------------------------------------------------------------------------
// utt_back: byte emitter
// Takes one descriptor at a time from the queue and presents its bytes one
// per transfer, with end-of-string fields on the closing NUL.
// ----------------------------------------------------------------------------
module utt_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  utt_pkg::entry_t               q_data,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    out_byte,
    output logic                          byte_written,
    output logic                          end_of_string,
    output logic [utt_pkg::LEN_W-1:0]     total_length,
    output logic                          truncated,
    output logic                          last
);
    import utt_pkg::*;

    entry_t            cur_reg, cur_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              busy_reg, busy_next;
    logic              is_last, finish, load;

    // Advance through the current descriptor, refill from the queue
    always_comb
    begin
        is_last  = (idx_reg == cur_reg.cnt - 1'b1);
        finish   = busy_reg && pop && is_last;
        load     = q_valid && (!busy_reg || finish);
        q_pop    = load;
        cur_next = cur_reg;
        idx_next = idx_reg;
        busy_next = busy_reg;
        if (load)
        begin
            cur_next  = q_data;
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && pop)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Drive the result fields
    always_comb
    begin
        empty         = !busy_reg;
        last          = is_last;
        end_of_string = cur_reg.has_end && is_last;
        out_byte      = cur_reg.seq[idx_reg];
        byte_written  = end_of_string ? cur_reg.end_wr : 1'b1;
        total_length  = end_of_string ? cur_reg.len : '0;
        truncated     = end_of_string && cur_reg.trunc;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    // Hold the descriptor
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

`ifndef NO_ASSERTIONS
    // The byte index stays inside a non-empty descriptor
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cur_reg.cnt != '0 && idx_reg < cur_reg.cnt))
        else $error("byte index outside descriptor");

    // The closing NUL is always the final result of its unit
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && end_of_string) |-> last)
        else $error("end of string not on last result");
`endif

endmodule

>>> rtl/core/utf16_to_utf8_transcoder_unit.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit: UTF-16 to UTF-8 transcoder
// Converts a stream of UTF-16 code units into UTF-8 bytes with a bounded
// destination, truncation report and a count-only mode.
//
//   Channel   Handshake           Payload
//   -------   -----------------   -----------------------------------------
//   input     push / full         code_unit
//   result    pop / empty         out_byte, byte_written, end_of_string,
//                                 total_length, truncated, last
//   config    cfg_wr_en           cfg_index, cfg_wdata (capacity, count_only)
//
// A unit is taken in any cycle the two-entry descriptor queue has room and is
// classified in that cycle; the back end then sends one byte per cycle in which
// pop is high. A unit causes up to six results; one that causes none puts
// nothing in the queue. A unit's bytes pass through a queue entry and then the
// back end's descriptor register. Reset sets capacity to 256, write mode, and
// empties the queue. full rises while the queue holds two descriptors; a
// stalled pop holds the back end, and the front takes units until the queue is full.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit #(
    parameter int MAX_CAPACITY = 65535
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [utt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [utt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            push,
    output logic                            full,
    input  logic [utt_pkg::UNIT_W-1:0]      code_unit,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      out_byte,
    output logic                            byte_written,
    output logic                            end_of_string,
    output logic [utt_pkg::LEN_W-1:0]       total_length,
    output logic                            truncated,
    output logic                            last
);
    import utt_pkg::*;

    logic   accept;
    logic   enq_valid;
    entry_t enq_entry;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    entry_t q_data;

    // Take a unit whenever the queue has room
    assign accept = push && !q_full;
    assign full   = q_full;

    utt_front #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .code_unit (code_unit),
        .enq_valid (enq_valid),
        .enq_entry (enq_entry)
    );

    utt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (enq_valid),
        .wr_data  (enq_entry),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data),
        .full     (q_full)
    );

    utt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .byte_written  (byte_written),
        .end_of_string (end_of_string),
        .total_length  (total_length),
        .truncated     (truncated),
        .last          (last)
    );

endmodule
